// File: rtl/qvd_pkg.sv
// Shared types and constants for the quantized vertex decoder with frame bounds.
// Used by qvd_front, qvd_fifo users, qvd_back and the top level; depends on nothing.
package qvd_pkg;

   // Axis lanes; the same order serves file axes (scale and offset registers)
   // and output axes (positions and bounds).
   localparam int AXES   = 3;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // Field widths
   localparam int COORD_W     = 8;
   localparam int NORMAL_W    = 8;
   localparam int POS_W       = 32;
   localparam int TERM_W      = 41;   // coord * scale + offset, exact and signed
   localparam int MAG_W       = 40;   // magnitude of that term
   localparam int LO_W        = 32;   // split point of the wide multiplications
   localparam int SQ_W        = 64;
   localparam int RAD_W       = 63;
   localparam int SIZE_GAIN_W = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Combined axis factor 0.07 * 0.55 as Q0.32, and the width of the gain sum
   // size_gain * factor + half LSB before the fraction shift.
   localparam int                     AXIS_GAIN_W = 28;
   localparam logic [AXIS_GAIN_W-1:0] AXIS_GAIN   = 28'd165356241;
   localparam int                     GAIN_SUM_W  = 60;

   localparam logic [NORMAL_W-1:0] NORMAL_LAST = 8'd161;

   localparam logic [POS_W-1:0] POS_MAX        = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] POS_MIN        = 32'h8000_0000;
   localparam logic [POS_W-1:0] NEG_MAG_LIMIT  = 32'h8000_0000;
   localparam logic [RAD_W-1:0] RAD_MAX        = {RAD_W{1'b1}};

   localparam logic [POS_W-1:0]       SCALE_RESET     = 32'h0001_0000;
   localparam logic [POS_W-1:0]       OFFSET_RESET    = 32'h0000_0000;
   localparam logic [SIZE_GAIN_W-1:0] SIZE_GAIN_RESET = 31'h0001_0000;

   // Queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_X   = 3'd0,
      CSR_SCALE_Y   = 3'd1,
      CSR_SCALE_Z   = 3'd2,
      CSR_OFFSET_X  = 3'd3,
      CSR_OFFSET_Y  = 3'd4,
      CSR_OFFSET_Z  = 3'd5,
      CSR_SIZE_GAIN = 3'd6
   } csr_index_type;

   // One output axis after the front end: term magnitude and final sign.
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
   } axis_term_type;

   // Work item handed from the front end to the back end.
   typedef struct packed {
      axis_term_type [AXES-1:0] axis;
      logic [NORMAL_W-1:0]      normal;
      logic                     frame_start;
   } work_type;

   // Finished result waiting in the result queue.
   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0] pos;
      logic [NORMAL_W-1:0]        normal;
      logic [AXES-1:0][POS_W-1:0] low;
      logic [AXES-1:0][POS_W-1:0] high;
      logic [RAD_W-1:0]           radius_sq;
   } result_type;

endpackage

// File: rtl/qvd_fifo.sv
// Small first-in first-out queue with a combinational head read.
// Generic in width and depth; depends on no package.
module qvd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");

endmodule

// File: rtl/qvd_front.sv
// Front end: configuration registers, gain precompute, input stage and per-axis term.
// Uses qvd_pkg; feeds the work queue that sits in front of qvd_back.
module qvd_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // configuration write channel
   input  logic                                           valid,
   output logic                                           ready,
   input  logic [qvd_pkg::CSR_INDEX_W-1:0]                csr_index,
   input  logic [qvd_pkg::CSR_DATA_W-1:0]                 csr_wdata,
   // vertex input
   input  logic                                           push,
   output logic                                           full,
   input  logic [qvd_pkg::COORD_W-1:0]                    coord_a,
   input  logic [qvd_pkg::COORD_W-1:0]                    coord_b,
   input  logic [qvd_pkg::COORD_W-1:0]                    coord_c,
   input  logic [qvd_pkg::NORMAL_W-1:0]                   normal_code,
   input  logic                                           frame_start,
   // work queue side
   output logic                                           mid_push,
   output qvd_pkg::work_type                              mid_data,
   input  logic                                           mid_full,
   output logic [qvd_pkg::GAIN_SUM_W-FRAC_BITS-1:0]       gain
);

   localparam int GAIN_W = qvd_pkg::GAIN_SUM_W - FRAC_BITS;

   logic [qvd_pkg::POS_W-1:0]       scale_ff  [qvd_pkg::AXES];
   logic [qvd_pkg::POS_W-1:0]       scale_in  [qvd_pkg::AXES];
   logic [qvd_pkg::POS_W-1:0]       offset_ff [qvd_pkg::AXES];
   logic [qvd_pkg::POS_W-1:0]       offset_in [qvd_pkg::AXES];
   logic [qvd_pkg::SIZE_GAIN_W-1:0] size_gain_ff, size_gain_in;
   logic [qvd_pkg::GAIN_SUM_W-1:0]  gain_sum;
   logic [GAIN_W-1:0]               gain_ff, gain_in;

   logic                            s1_valid_ff, s1_valid_in;
   logic [qvd_pkg::COORD_W-1:0]     s1_coord_a_ff, s1_coord_b_ff, s1_coord_c_ff;
   logic [qvd_pkg::NORMAL_W-1:0]    s1_normal_ff;
   logic                            s1_frame_start_ff;
   logic                            accept;

   // Exact term coord * scale + offset, split into magnitude and final sign
   function automatic qvd_pkg::axis_term_type make_term(
      input logic [qvd_pkg::COORD_W-1:0] coord,
      input logic [qvd_pkg::POS_W-1:0]   scale,
      input logic [qvd_pkg::POS_W-1:0]   offset,
      input logic                        negate
   );
      logic signed [qvd_pkg::TERM_W-1:0] c_ext;
      logic signed [qvd_pkg::TERM_W-1:0] s_ext;
      logic signed [qvd_pkg::TERM_W-1:0] o_ext;
      logic signed [qvd_pkg::TERM_W-1:0] term;
      logic        [qvd_pkg::TERM_W-1:0] mag;
      qvd_pkg::axis_term_type            res;
      c_ext    = qvd_pkg::TERM_W'(signed'({1'b0, coord}));
      s_ext    = qvd_pkg::TERM_W'(signed'(scale));
      o_ext    = qvd_pkg::TERM_W'(signed'(offset));
      term     = c_ext * s_ext + o_ext;
      mag      = term[qvd_pkg::TERM_W-1] ? qvd_pkg::TERM_W'(-term) : qvd_pkg::TERM_W'(term);
      res.mag  = mag[qvd_pkg::MAG_W-1:0];
      res.neg  = term[qvd_pkg::TERM_W-1] ^ negate;
      return res;
   endfunction

   assign ready = 1'b1;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      scale_in     = scale_ff;
      offset_in    = offset_ff;
      size_gain_in = size_gain_ff;
      if (valid) begin
         unique case (qvd_pkg::csr_index_type'(csr_index))
            qvd_pkg::CSR_SCALE_X:   scale_in[qvd_pkg::AXIS_X]  = csr_wdata;
            qvd_pkg::CSR_SCALE_Y:   scale_in[qvd_pkg::AXIS_Y]  = csr_wdata;
            qvd_pkg::CSR_SCALE_Z:   scale_in[qvd_pkg::AXIS_Z]  = csr_wdata;
            qvd_pkg::CSR_OFFSET_X:  offset_in[qvd_pkg::AXIS_X] = csr_wdata;
            qvd_pkg::CSR_OFFSET_Y:  offset_in[qvd_pkg::AXIS_Y] = csr_wdata;
            qvd_pkg::CSR_OFFSET_Z:  offset_in[qvd_pkg::AXIS_Z] = csr_wdata;
            qvd_pkg::CSR_SIZE_GAIN: size_gain_in = csr_wdata[qvd_pkg::SIZE_GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < qvd_pkg::AXES; a++) begin
            scale_ff[a]  <= qvd_pkg::SCALE_RESET;
            offset_ff[a] <= qvd_pkg::OFFSET_RESET;
         end
         size_gain_ff <= qvd_pkg::SIZE_GAIN_RESET;
      end else begin
         scale_ff     <= scale_in;
         offset_ff    <= offset_in;
         size_gain_ff <= size_gain_in;
      end
   end

   // Precompute gain = (size_gain * factor + half LSB) >> FRAC_BITS, held as Q.32
   always_comb begin
      gain_sum = qvd_pkg::GAIN_SUM_W'(size_gain_ff) * qvd_pkg::GAIN_SUM_W'(qvd_pkg::AXIS_GAIN)
               + (qvd_pkg::GAIN_SUM_W'(1) << (FRAC_BITS - 1));
      gain_in  = gain_sum[qvd_pkg::GAIN_SUM_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   assign gain = gain_ff;

   // Input stage: hold the transaction while the work queue is full
   assign full        = s1_valid_ff && mid_full;
   assign accept      = push && !full;
   assign s1_valid_in = accept || (s1_valid_ff && mid_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_coord_a_ff     <= coord_a;
         s1_coord_b_ff     <= coord_b;
         s1_coord_c_ff     <= coord_c;
         s1_normal_ff      <= normal_code;
         s1_frame_start_ff <= frame_start;
      end
   end

   // Permute axes: out x from file y (negated), out y from file z, out z from file x (negated)
   always_comb begin
      mid_data.axis[qvd_pkg::AXIS_X] = make_term(s1_coord_b_ff, scale_ff[qvd_pkg::AXIS_Y],
                                                 offset_ff[qvd_pkg::AXIS_Y], 1'b1);
      mid_data.axis[qvd_pkg::AXIS_Y] = make_term(s1_coord_c_ff, scale_ff[qvd_pkg::AXIS_Z],
                                                 offset_ff[qvd_pkg::AXIS_Z], 1'b0);
      mid_data.axis[qvd_pkg::AXIS_Z] = make_term(s1_coord_a_ff, scale_ff[qvd_pkg::AXIS_X],
                                                 offset_ff[qvd_pkg::AXIS_X], 1'b1);
      mid_data.normal      = (s1_normal_ff > qvd_pkg::NORMAL_LAST) ? qvd_pkg::NORMAL_LAST
                                                                   : s1_normal_ff;
      mid_data.frame_start = s1_frame_start_ff;
   end

   assign mid_push = s1_valid_ff && !mid_full;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && mid_full |=> s1_valid_ff)
      else $error("input stage dropped a transaction while the work queue was full");

endmodule

// File: rtl/qvd_back.sv
// Back end: gain multiply in partial products, rounding and clamp, squares, bounds update.
// Uses qvd_pkg; drains the work queue and fills the result queue.
module qvd_back #(
   parameter int GAIN_W = 44
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 mid_pop,
   input  qvd_pkg::work_type    mid_data,
   input  logic                 mid_empty,
   input  logic [GAIN_W-1:0]    gain,
   output logic                 out_push,
   output qvd_pkg::result_type  out_data,
   input  logic                 out_full
);

   localparam int LO_W      = qvd_pkg::LO_W;
   localparam int POS_W     = qvd_pkg::POS_W;
   localparam int AXES      = qvd_pkg::AXES;
   localparam int GAIN_HI_W = GAIN_W - LO_W;
   localparam int MAG_HI_W  = qvd_pkg::MAG_W - LO_W;
   localparam int P00_W     = 2 * LO_W;
   localparam int P01_W     = LO_W + GAIN_HI_W;
   localparam int P10_W     = MAG_HI_W + LO_W;
   localparam int P11_W     = MAG_HI_W + GAIN_HI_W;
   localparam int PROD_W    = qvd_pkg::MAG_W + GAIN_W;
   localparam int Q_W       = PROD_W - LO_W;

   logic advance;

   // stage 1: partial products
   logic                         b1_valid_ff;
   logic [P00_W-1:0]             p00_ff [AXES];
   logic [P00_W-1:0]             p00_in [AXES];
   logic [P01_W-1:0]             p01_ff [AXES];
   logic [P01_W-1:0]             p01_in [AXES];
   logic [P10_W-1:0]             p10_ff [AXES];
   logic [P10_W-1:0]             p10_in [AXES];
   logic [P11_W-1:0]             p11_ff [AXES];
   logic [P11_W-1:0]             p11_in [AXES];
   logic [AXES-1:0]              b1_neg_ff;
   logic [qvd_pkg::NORMAL_W-1:0] b1_normal_ff;
   logic                         b1_fs_ff;

   // stage 2: clamped positions
   logic                         b2_valid_ff;
   logic [POS_W-1:0]             b2_pos_ff [AXES];
   logic [POS_W-1:0]             b2_pos_in [AXES];
   logic [qvd_pkg::NORMAL_W-1:0] b2_normal_ff;
   logic                         b2_fs_ff;

   // stage 3: squares
   logic                         b3_valid_ff;
   logic [POS_W-1:0]             b3_pos_ff [AXES];
   logic [qvd_pkg::RAD_W-1:0]    b3_sq_ff  [AXES];
   logic [qvd_pkg::RAD_W-1:0]    b3_sq_in  [AXES];
   logic [qvd_pkg::NORMAL_W-1:0] b3_normal_ff;
   logic                         b3_fs_ff;

   // running frame bounds
   logic [POS_W-1:0]             min_ff [AXES];
   logic [POS_W-1:0]             min_in [AXES];
   logic [POS_W-1:0]             max_ff [AXES];
   logic [POS_W-1:0]             max_in [AXES];
   logic [qvd_pkg::RAD_W-1:0]    rad_ff, rad_in;

   // The whole pipeline stalls while the result queue is full
   assign advance  = !out_full;
   assign mid_pop  = advance && !mid_empty;
   assign out_push = advance && b3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= !mid_empty;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   // Stage 1: split magnitude times gain into four products of at most 32x32
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         p00_in[a] = P00_W'(mid_data.axis[a].mag[LO_W-1:0]) * P00_W'(gain[LO_W-1:0]);
         p01_in[a] = P01_W'(mid_data.axis[a].mag[LO_W-1:0]) * P01_W'(gain[GAIN_W-1:LO_W]);
         p10_in[a] = P10_W'(mid_data.axis[a].mag[qvd_pkg::MAG_W-1:LO_W])
                   * P10_W'(gain[LO_W-1:0]);
         p11_in[a] = P11_W'(mid_data.axis[a].mag[qvd_pkg::MAG_W-1:LO_W])
                   * P11_W'(gain[GAIN_W-1:LO_W]);
      end
   end

   // Stage 2: sum, round half up on the magnitude, clamp to 32 bits, apply sign
   always_comb begin : b2_round
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] rnd;
      logic [Q_W-1:0]    q;
      logic [POS_W-1:0]  lim;
      logic [POS_W-1:0]  qc;
      for (int a = 0; a < AXES; a++) begin
         prod = PROD_W'(p00_ff[a])
              + (PROD_W'(p01_ff[a]) << LO_W)
              + (PROD_W'(p10_ff[a]) << LO_W)
              + (PROD_W'(p11_ff[a]) << (2 * LO_W));
         rnd  = prod + (PROD_W'(1) << (LO_W - 1));
         q    = rnd[PROD_W-1:LO_W];
         lim  = b1_neg_ff[a] ? qvd_pkg::NEG_MAG_LIMIT : qvd_pkg::POS_MAX;
         qc   = (q > Q_W'(lim)) ? lim : q[POS_W-1:0];
         b2_pos_in[a] = b1_neg_ff[a] ? (POS_W'(0) - qc) : qc;
      end
   end

   // Stage 3: squared magnitude per axis
   always_comb begin : b3_square
      logic [POS_W-1:0]        mag;
      logic [qvd_pkg::SQ_W-1:0] sq;
      for (int a = 0; a < AXES; a++) begin
         mag = b2_pos_ff[a][POS_W-1] ? (POS_W'(0) - b2_pos_ff[a]) : b2_pos_ff[a];
         sq  = qvd_pkg::SQ_W'(mag) * qvd_pkg::SQ_W'(mag);
         b3_sq_in[a] = sq[qvd_pkg::RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         for (int a = 0; a < AXES; a++) begin
            b1_neg_ff[a] <= mid_data.axis[a].neg;
         end
         b1_normal_ff <= mid_data.normal;
         b1_fs_ff     <= mid_data.frame_start;
         b2_pos_ff    <= b2_pos_in;
         b2_normal_ff <= b1_normal_ff;
         b2_fs_ff     <= b1_fs_ff;
         b3_pos_ff    <= b2_pos_ff;
         b3_sq_ff     <= b3_sq_in;
         b3_normal_ff <= b2_normal_ff;
         b3_fs_ff     <= b2_fs_ff;
      end
   end

   // Final step: restart on frame start, compare-select bounds, saturate and keep radius
   always_comb begin : bounds_update
      logic [POS_W-1:0]         low_base;
      logic [POS_W-1:0]         high_base;
      logic [qvd_pkg::RAD_W-1:0] rad_base;
      logic [qvd_pkg::SQ_W-1:0]  rsum;
      logic [qvd_pkg::RAD_W-1:0] rsat;
      for (int a = 0; a < AXES; a++) begin
         low_base  = b3_fs_ff ? qvd_pkg::POS_MAX : min_ff[a];
         high_base = b3_fs_ff ? qvd_pkg::POS_MIN : max_ff[a];
         min_in[a] = ($signed(b3_pos_ff[a]) < $signed(low_base))  ? b3_pos_ff[a] : low_base;
         max_in[a] = ($signed(b3_pos_ff[a]) > $signed(high_base)) ? b3_pos_ff[a] : high_base;
         out_data.pos[a]  = b3_pos_ff[a];
         out_data.low[a]  = min_in[a];
         out_data.high[a] = max_in[a];
      end
      rad_base = b3_fs_ff ? '0 : rad_ff;
      rsum = qvd_pkg::SQ_W'(b3_sq_ff[qvd_pkg::AXIS_X])
           + qvd_pkg::SQ_W'(b3_sq_ff[qvd_pkg::AXIS_Y])
           + qvd_pkg::SQ_W'(b3_sq_ff[qvd_pkg::AXIS_Z]);
      rsat = rsum[qvd_pkg::SQ_W-1] ? qvd_pkg::RAD_MAX : rsum[qvd_pkg::RAD_W-1:0];
      rad_in = (rsat > rad_base) ? rsat : rad_base;
      out_data.radius_sq = rad_in;
      out_data.normal    = b3_normal_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            min_ff[a] <= qvd_pkg::POS_MAX;
            max_ff[a] <= qvd_pkg::POS_MIN;
         end
         rad_ff <= '0;
      end else if (out_push) begin
         min_ff <= min_in;
         max_ff <= max_in;
         rad_ff <= rad_in;
      end
   end

   a_low_bounds_pos: assert property (@(posedge clock) disable iff (reset)
      out_push |->
         ($signed(out_data.low[qvd_pkg::AXIS_X]) <= $signed(out_data.pos[qvd_pkg::AXIS_X]))
      && ($signed(out_data.low[qvd_pkg::AXIS_Y]) <= $signed(out_data.pos[qvd_pkg::AXIS_Y]))
      && ($signed(out_data.low[qvd_pkg::AXIS_Z]) <= $signed(out_data.pos[qvd_pkg::AXIS_Z])))
      else $error("frame minimum above the current position");

   a_high_bounds_pos: assert property (@(posedge clock) disable iff (reset)
      out_push |->
         ($signed(out_data.high[qvd_pkg::AXIS_X]) >= $signed(out_data.pos[qvd_pkg::AXIS_X]))
      && ($signed(out_data.high[qvd_pkg::AXIS_Y]) >= $signed(out_data.pos[qvd_pkg::AXIS_Y]))
      && ($signed(out_data.high[qvd_pkg::AXIS_Z]) >= $signed(out_data.pos[qvd_pkg::AXIS_Z])))
      else $error("frame maximum below the current position");

   a_radius_grows: assert property (@(posedge clock) disable iff (reset)
      out_push && !b3_fs_ff |-> out_data.radius_sq >= rad_ff)
      else $error("radius shrank within a frame");

endmodule

// File: rtl/quantized_vertex_decode_bounds.sv
// Throughput: one vertex per cycle unless a full work queue holds the input stage; the back
// pipeline (four partial products per axis, round, square, bounds) stalls as a whole only
// while the two-entry result queue is full.
// Reset: empties both queues and the pipeline, restores the configuration defaults and
// the frame bounds (minimum most positive, maximum most negative, radius zero).
module quantized_vertex_decode_bounds #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // vertex input
   input  logic                                 push,
   output logic                                 full,
   input  logic [qvd_pkg::COORD_W-1:0]          req_coord_a,
   input  logic [qvd_pkg::COORD_W-1:0]          req_coord_b,
   input  logic [qvd_pkg::COORD_W-1:0]          req_coord_c,
   input  logic [qvd_pkg::NORMAL_W-1:0]         req_normal_code,
   input  logic                                 req_frame_start,
   // results
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_pos_z,
   output logic [qvd_pkg::NORMAL_W-1:0]         rsp_normal_out,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_low_x,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_low_y,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_low_z,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_high_x,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_high_y,
   output logic signed [qvd_pkg::POS_W-1:0]     rsp_high_z,
   output logic [qvd_pkg::RAD_W-1:0]            rsp_radius_sq,
   // configuration writes
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [qvd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [qvd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int GAIN_W = qvd_pkg::GAIN_SUM_W - FRAC_BITS;
   localparam int WORK_W = $bits(qvd_pkg::work_type);
   localparam int RES_W  = $bits(qvd_pkg::result_type);

   logic                mid_push, mid_full, mid_pop, mid_empty;
   qvd_pkg::work_type   mid_in_data, mid_out_data;
   logic [GAIN_W-1:0]   gain;
   logic                out_push, out_full;
   qvd_pkg::result_type out_in_data, out_head;

   qvd_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .valid       (valid),
      .ready       (ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .full        (full),
      .coord_a     (req_coord_a),
      .coord_b     (req_coord_b),
      .coord_c     (req_coord_c),
      .normal_code (req_normal_code),
      .frame_start (req_frame_start),
      .mid_push    (mid_push),
      .mid_data    (mid_in_data),
      .mid_full    (mid_full),
      .gain        (gain)
   );

   qvd_fifo #(
      .WIDTH (WORK_W),
      .DEPTH (qvd_pkg::MID_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .empty     (mid_empty)
   );

   qvd_back #(
      .GAIN_W (GAIN_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_pop   (mid_pop),
      .mid_data  (mid_out_data),
      .mid_empty (mid_empty),
      .gain      (gain),
      .out_push  (out_push),
      .out_data  (out_in_data),
      .out_full  (out_full)
   );

   qvd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (qvd_pkg::OUT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_data),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_head),
      .empty     (empty)
   );

   // Unpack the oldest result onto the ports
   assign rsp_pos_x      = out_head.pos[qvd_pkg::AXIS_X];
   assign rsp_pos_y      = out_head.pos[qvd_pkg::AXIS_Y];
   assign rsp_pos_z      = out_head.pos[qvd_pkg::AXIS_Z];
   assign rsp_normal_out = out_head.normal;
   assign rsp_low_x      = out_head.low[qvd_pkg::AXIS_X];
   assign rsp_low_y      = out_head.low[qvd_pkg::AXIS_Y];
   assign rsp_low_z      = out_head.low[qvd_pkg::AXIS_Z];
   assign rsp_high_x     = out_head.high[qvd_pkg::AXIS_X];
   assign rsp_high_y     = out_head.high[qvd_pkg::AXIS_Y];
   assign rsp_high_z     = out_head.high[qvd_pkg::AXIS_Z];
   assign rsp_radius_sq  = out_head.radius_sq;

endmodule
